/* design/mlta_pkg.sv */
`default_nettype none
package mlta_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_LEARN  = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DONE
  } state_e;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned PORT_W  = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned HASH_W  = 16;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd30;
  localparam logic [CNT_W-1:0] CNT_MAX   = 11'd2047;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [MAC_W-1:0]  mac_address;
    logic [PORT_W-1:0] port_number;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port_out;
    logic              status;
    logic [CNT_W-1:0]  removed_count;
  } rsp_t;

  // xor-fold of the address into 16 bits
  function automatic logic [HASH_W-1:0] mac_fold(input logic [MAC_W-1:0] m);
    mac_fold = m[15:0] ^ m[31:16] ^ m[47:32];
  endfunction

endpackage
`default_nettype wire

/* design/mlta_if.sv */
`default_nettype none
interface mlta_req_if;
  import mlta_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlta_rsp_if;
  import mlta_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/mlta_ram.sv */
`default_nettype none
// one row per bucket: valid bits, macs, ports and timestamps of all ways
module mlta_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* design/mac_learning_table_aging_unit.sv */
`default_nettype none
// channel  | dir | payload
// req      | in  | opcode, mac_address, port_number
// rsp      | out | hit, port_out, status, removed_count
// cfg      | in  | aging_timeout
// lookup and learn go through bucket row read, modify and write back, and result.
// a tick sweeps every bucket row, one row a cycle.
// after reset a clearing pass over every bucket row empties the table; no request
// is taken until it ends. a pending result holds the block until it transfers.
module mac_learning_table_aging_unit
  import mlta_pkg::*;
#(
  parameter int unsigned Buckets = 256,
  parameter int unsigned Ways    = 4,
  parameter int unsigned Ports   = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TMO_W-1:0]  cfg_wdata_i,
  mlta_req_if.sink               req,
  mlta_rsp_if.source             rsp
);
  localparam int unsigned BW   = $clog2(Buckets);
  localparam int unsigned WW   = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned EW   = 1 + MAC_W + PORT_W + TIME_W;
  localparam int unsigned RW   = EW * Ways;
  localparam int unsigned PCW  = $clog2(Ways + 1);

  typedef struct packed {
    logic              vld;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] seen;
  } ent_t;

  state_e state_q, state_d;
  logic [TMO_W-1:0]  tmo_q;
  logic [TIME_W-1:0] now_q, now_d;
  req_t              req_q;
  logic [BW-1:0]     ptr_q, ptr_d;
  logic              sweep_last_q, sweep_last_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  rsp_t              rsp_q, rsp_d;

  logic          we;
  logic [BW-1:0] waddr, raddr;
  logic [RW-1:0] wrow, rrow;
  ent_t          rent [Ways];
  ent_t          went [Ways];

  logic [BW-1:0] bucket;
  assign bucket = BW'(mac_fold(req.data.mac_address) % HASH_W'(Buckets));

  mlta_ram #(.Depth(Buckets), .Width(RW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wrow),
    .raddr_i(raddr), .rdata_o(rrow)
  );

  // unpack row
  for (genvar g = 0; g < Ways; g++) begin : g_row
    assign rent[g] = rrow[g*EW +: EW];
    assign wrow[g*EW +: EW] = went[g];
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= TMO_RESET;
    end else if (cfg_we_i) begin
      tmo_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (ptr_q == BW'(Buckets - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req.valid) begin
          state_d = (op_e'(req.data.opcode) == OP_TICK) ? ST_SWEEP : ST_READ;
        end
      end
      ST_READ:  state_d = ST_DONE;
      ST_SWEEP: if (sweep_last_q) state_d = ST_DONE;
      ST_DONE:  if (rsp.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // per-row match, free way and aged entries
  logic          match;
  logic [WW-1:0] match_w;
  logic          free;
  logic [WW-1:0] free_w;
  logic [PCW-1:0] aged_n;
  logic [Ways-1:0] aged;
  always_comb begin
    match = 1'b0; match_w = '0; free = 1'b0; free_w = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (rent[w].vld && rent[w].mac == req_q.mac_address) begin
        match = 1'b1; match_w = WW'(w);
      end
      if (!rent[w].vld) begin
        free = 1'b1; free_w = WW'(w);
      end
    end
    aged_n = '0;
    for (int w = 0; w < Ways; w++) begin
      aged[w] = rent[w].vld && ((now_q - rent[w].seen) >= {16'd0, tmo_q});
      aged_n  = aged_n + PCW'(aged[w]);
    end
  end

  // datapath and memory control
  logic [CNT_W:0] cnt_sum;
  always_comb begin
    we = 1'b0; waddr = ptr_q; raddr = bucket;
    now_d = now_q; ptr_d = ptr_q; cnt_d = cnt_q; rsp_d = rsp_q;
    sweep_last_d = sweep_last_q;
    cnt_sum = {1'b0, cnt_q} + (CNT_W + 1)'(aged_n);
    for (int w = 0; w < Ways; w++) went[w] = rent[w];
    req.ready = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        for (int w = 0; w < Ways; w++) went[w] = '0;
        ptr_d = ptr_q + 1'b1;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        ptr_d = bucket; cnt_d = '0;
        sweep_last_d = (Buckets == 1);
        if (req.valid && op_e'(req.data.opcode) == OP_TICK) begin
          raddr = '0; ptr_d = '0; now_d = now_q + 1'b1;
        end
      end
      ST_READ: begin
        rsp_d = '0;
        unique case (op_e'(req_q.opcode))
          OP_LOOKUP: begin
            if (match) begin
              we = 1'b1;
              went[match_w].seen = now_q;
              rsp_d.hit = 1'b1;
              rsp_d.port_out = rent[match_w].port;
            end
          end
          OP_LEARN: begin
            if (32'(req_q.port_number) < Ports) begin
              if (match || free) begin
                we = 1'b1;
                went[match ? match_w : free_w] =
                  '{vld: 1'b1, mac: req_q.mac_address, port: req_q.port_number,
                    seen: now_q};
              end else begin
                rsp_d.status = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_SWEEP: begin
        we = 1'b1;
        for (int w = 0; w < Ways; w++) if (aged[w]) went[w].vld = 1'b0;
        cnt_d = cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
        raddr = ptr_q + 1'b1; ptr_d = ptr_q + 1'b1;
        sweep_last_d = (ptr_d == BW'(Buckets - 1));
        rsp_d = '0;
        rsp_d.removed_count = cnt_d;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign rsp.valid = (state_q == ST_DONE);
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; now_q <= '0; ptr_q <= '0; cnt_q <= '0;
      sweep_last_q <= 1'b0;
    end else begin
      state_q <= state_d; now_q <= now_d; ptr_q <= ptr_d; cnt_q <= cnt_d;
      sweep_last_q <= sweep_last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == ST_IDLE && req.valid) begin
      req_q <= req.data;
    end
  end
endmodule
`default_nettype wire

/* design/mlta_checker.sv */
`default_nettype none
module mlta_checker
  import mlta_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);
  // a stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp");
  // no request taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("busy");
  // a hit never comes with a drop
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !(rsp_data.hit && rsp_data.status)) else $error("excl");
  // miss reports port zero
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_data.hit |-> rsp_data.port_out == '0) else $error("miss");
endmodule

bind mac_learning_table_aging_unit mlta_checker u_chk (
  .clk_i, .rst_ni, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire
